@@ rtl/mck_pkg.sv @@
// morse character keyer: shared types, unit constants and the letter pattern table
// no dependencies

package mck_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNITS_W = 3;
    localparam int TU_W    = 16;
    localparam int MS_W    = 19;
    localparam int NSYM    = 4;
    localparam int SEG_W   = 3;

    localparam logic [UNITS_W-1:0] UNIT_DOT        = 3'd1;
    localparam logic [UNITS_W-1:0] UNIT_DASH       = 3'd3;
    localparam logic [UNITS_W-1:0] UNIT_GAP        = 3'd1;
    localparam logic [UNITS_W-1:0] UNIT_LETTER_END = 3'd4;
    localparam logic [UNITS_W-1:0] UNIT_WORD       = 3'd7;

    localparam logic [TU_W-1:0] TIME_UNIT_RESET = 16'd100;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic REG_TIME_UNIT = 1'b0;

    // classified character: a word space or a letter pattern
    typedef struct packed {
        logic                is_word;
        logic [2:0]          count;
        logic [NSYM-1:0]     symbols;
    } cmd_t;

    // high nibble symbol count, low nibble symbols, first symbol in bit 0, 1 = dash
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] code;
        begin
            unique case (idx)
                5'd0:    code = 8'h22;
                5'd1:    code = 8'h41;
                5'd2:    code = 8'h45;
                5'd3:    code = 8'h31;
                5'd4:    code = 8'h10;
                5'd5:    code = 8'h44;
                5'd6:    code = 8'h33;
                5'd7:    code = 8'h40;
                5'd8:    code = 8'h20;
                5'd9:    code = 8'h4E;
                5'd10:   code = 8'h35;
                5'd11:   code = 8'h42;
                5'd12:   code = 8'h23;
                5'd13:   code = 8'h21;
                5'd14:   code = 8'h37;
                5'd15:   code = 8'h46;
                5'd16:   code = 8'h4B;
                5'd17:   code = 8'h32;
                5'd18:   code = 8'h30;
                5'd19:   code = 8'h11;
                5'd20:   code = 8'h34;
                5'd21:   code = 8'h48;
                5'd22:   code = 8'h36;
                5'd23:   code = 8'h49;
                5'd24:   code = 8'h4D;
                5'd25:   code = 8'h43;
                default: code = 8'h00;
            endcase
            return code;
        end
    endfunction

endpackage

@@ rtl/mck_front.sv @@
// morse character keyer front end: classifies characters into letter patterns or word spaces
// depends on mck_pkg

module mck_front
    import mck_pkg::*;
(
    input  logic [CHAR_W-1:0] character,
    input  logic              accept,
    output logic              cmd_push,
    output cmd_t              cmd
);

    logic [CHAR_W-1:0] upper;
    logic [CHAR_W-1:0] offset;
    logic [7:0]        code;
    logic              is_space;
    logic              is_letter;

    always_comb
    begin
        is_space = (character == CHAR_SPACE);
        if (character >= CHAR_LOWER_A && character <= CHAR_LOWER_Z)
        begin
            upper = character - CASE_OFFSET;
        end
        else
        begin
            upper = character;
        end
        is_letter = (upper >= CHAR_UPPER_A) && (upper <= CHAR_UPPER_Z);
        offset    = upper - CHAR_UPPER_A;
        code      = letter_code(offset[4:0]);

        cmd.is_word = is_space;
        cmd.count   = is_space ? 3'd0 : code[6:4];
        cmd.symbols = is_space ? '0 : code[3:0];
        cmd_push    = accept && (is_space || is_letter);
    end

endmodule

@@ rtl/mck_cmd_fifo.sv @@
// morse character keyer: short request queue between front end and segment sequencer
// depends on mck_pkg

module mck_cmd_fifo
    import mck_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/mck_back.sv @@
// morse character keyer back end: steps through segments of a request into the result register
// depends on mck_pkg

module mck_back
    import mck_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TU_W-1:0]     time_unit_ms,
    input  logic                cmd_empty,
    input  cmd_t                cmd_head,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic                led_on,
    output logic [UNITS_W-1:0]  length_units,
    output logic [MS_W-1:0]     length_ms,
    output logic                last_segment
);

    logic               active_reg;
    logic               active_next;
    cmd_t               cur_reg;
    cmd_t               cur_next;
    logic [SEG_W-1:0]   seg_reg;
    logic [SEG_W-1:0]   seg_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               led_on_reg;
    logic [UNITS_W-1:0] units_reg;
    logic [MS_W-1:0]    ms_reg;
    logic               last_reg;

    cmd_t               src;
    logic [SEG_W-1:0]   src_seg;
    logic               src_valid;
    logic               emit;
    logic [1:0]         sym_idx;
    logic               seg_on;
    logic               seg_final;
    logic [UNITS_W-1:0] seg_units;
    logic               seg_last;

    assign empty        = !out_valid_reg;
    assign led_on       = led_on_reg;
    assign length_units = units_reg;
    assign length_ms    = ms_reg;
    assign last_segment = last_reg;

    always_comb
    begin
        src       = active_reg ? cur_reg : cmd_head;
        src_seg   = active_reg ? seg_reg : '0;
        src_valid = active_reg || !cmd_empty;
        emit      = src_valid && (!out_valid_reg || pop);

        sym_idx   = src_seg[2:1];
        seg_final = ({1'b0, sym_idx} + 3'd1) == src.count;
        if (src.is_word)
        begin
            seg_on    = 1'b0;
            seg_units = UNIT_WORD;
            seg_last  = 1'b1;
        end
        else if (!src_seg[0])
        begin
            seg_on    = 1'b1;
            seg_units = src.symbols[sym_idx] ? UNIT_DASH : UNIT_DOT;
            seg_last  = 1'b0;
        end
        else
        begin
            seg_on    = 1'b0;
            seg_units = seg_final ? UNIT_LETTER_END : UNIT_GAP;
            seg_last  = seg_final;
        end

        cmd_pop        = emit && !active_reg;
        active_next    = active_reg;
        cur_next       = cur_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            seg_next       = src_seg + 1'b1;
            active_next    = !seg_last;
            if (!active_reg)
            begin
                cur_next = cmd_head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            led_on_reg <= seg_on;
            units_reg  <= seg_units;
            ms_reg     <= MS_W'(seg_units) * MS_W'(time_unit_ms);
            last_reg   <= seg_last;
        end
    end

endmodule

@@ rtl/morse_char_keyer_top.sv @@
// morse character keyer top level: configuration register, front end, request queue, back end
// depends on mck_pkg, mck_front, mck_cmd_fifo, mck_back
// path: a character is queued, then its first segment is loaded into the result register
// segments: a letter of n symbols gives 2n segments in the segment sequencer, a space one,
// other characters none; the front end takes a character every cycle while the queue has room
// reset: queue and result register empty, time_unit_ms returns to 100

module morse_char_keyer_top
    import mck_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  character,
    output logic               empty,
    input  logic               pop,
    output logic               led_on,
    output logic [UNITS_W-1:0] length_units,
    output logic [MS_W-1:0]    length_ms,
    output logic               last_segment
);

    logic [TU_W-1:0] time_unit_reg;
    logic            cfg_wr;
    logic            cmd_push;
    cmd_t            cmd_in;
    logic            cmd_full;
    logic            cmd_empty;
    logic            cmd_pop;
    cmd_t            cmd_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIME_UNIT);
    assign prdata = (paddr[2] == REG_TIME_UNIT) ? {16'd0, time_unit_reg} : 32'd0;
    assign full   = cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_unit_reg <= TIME_UNIT_RESET;
        end
        else if (cfg_wr)
        begin
            time_unit_reg <= pwdata[TU_W-1:0];
        end
    end

    mck_front u_front (
        .character (character),
        .accept    (push && !cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    mck_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .empty   (cmd_empty),
        .rd_data (cmd_head)
    );

    mck_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .time_unit_ms (time_unit_reg),
        .cmd_empty    (cmd_empty),
        .cmd_head     (cmd_head),
        .cmd_pop      (cmd_pop),
        .empty        (empty),
        .pop          (pop),
        .led_on       (led_on),
        .length_units (length_units),
        .length_ms    (length_ms),
        .last_segment (last_segment)
    );

endmodule
